@@ rtl/core/bca_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucket chain allocator package
// Shared request and response types and codes for the allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

  // Number of buckets in the pool; the response fields are sized for it.
  localparam int BUCKETS = 1024;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [25:0] vertex_count;
    logic [10:0] bucket_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] result_bucket;
    logic [15:0] bucket_fill;
    logic [10:0] free_count;
  } rsp_t;

endpackage

@@ rtl/core/bucket_chain_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Bucket chain allocator
// Fixed-size bucket pool with a FIFO free list and per-bucket link tables.
// ----------------------------------------------------------------------------
// One request is handled at a time and the request channel is not ready while
// one is in flight. A query reads the fill and link tables in the states S_QRD
// and S_QWAIT. An allocate with a nonzero count and bucket size first runs a
// bit-serial divider for the bucket count, then pops one bucket per S_POPRD and
// S_POPWR pair, since the free queue has one read port with registered data. A
// deallocate visits one chain entry per S_WLKRD and S_WLKWR pair, limited by the
// registered read of the link table. The free queue is filled with ids 0 to
// BUCKETS-1 by a clearing pass after reset, during which no request is accepted.
module bucket_chain_allocator_top
  import bca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  localparam int AW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);
  localparam logic [CW-1:0] NONE = CW'(BUCKETS);
  localparam logic [AW-1:0] LAST = AW'(BUCKETS - 1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_POPRD = 4'd3;
  localparam logic [3:0] S_POPWR = 4'd4;
  localparam logic [3:0] S_WLKRD = 4'd5;
  localparam logic [3:0] S_WLKWR = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QWAIT = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0]    state;
  logic [15:0]   bucket_size;
  req_t          cur_req;
  logic [25:0]   remain;
  logic [CW-1:0] prev;
  logic [CW-1:0] cur;
  logic [CW-1:0] steps;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] total;
  logic [AW-1:0] init_idx;
  rsp_t          out_reg;

  // Memory ports.
  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [AW-1:0] q_wdata;
  logic [AW-1:0] q_raddr;
  logic [AW-1:0] q_rdata;
  logic          t_we;
  logic [AW-1:0] t_waddr;
  logic [AW-1:0] t_raddr;
  logic [15:0]   f_rdata;
  logic [CW-1:0] n_rdata;
  logic [15:0]   amount;

  logic          div_start;
  logic          div_done;
  logic [25:0]   div_q;

  bca_ram #(.Width(AW), .Depth(BUCKETS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  bca_ram #(.Width(16), .Depth(BUCKETS)) u_fill (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(amount),
    .raddr(t_raddr), .rdata(f_rdata)
  );
  bca_ram #(.Width(CW), .Depth(BUCKETS)) u_link (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(prev),
    .raddr(t_raddr), .rdata(n_rdata)
  );
  bca_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cur_req.vertex_count),
    .divisor(bucket_size), .done(div_done), .quotient(div_q)
  );

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign rsp       = out_reg;
  assign amount    = (remain < {10'd0, bucket_size}) ? remain[15:0] : bucket_size;
  assign div_start = (state == S_DIV) && !div_done && (steps == '0);

  // Memory port steering.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail;
    q_wdata = cur[AW-1:0];
    q_raddr = head;
    t_we    = (state == S_POPWR);
    t_waddr = q_rdata;
    t_raddr = (state == S_QRD) ? cur_req.bucket_id[AW-1:0] : cur[AW-1:0];
    if (state == S_INIT) begin
      q_we    = 1'b1;
      q_waddr = init_idx;
      q_wdata = init_idx;
    end else if (state == S_WLKRD && total < NONE) begin
      q_we = 1'b1;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= 16'd3;
    end else if (cfg_valid && cfg_ready) begin
      bucket_size <= cfg_data;
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_idx <= '0;
      head     <= '0;
      tail     <= '0;
      total    <= NONE;
      steps    <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur_req <= req;
            cur     <= req.bucket_id[CW-1:0];
            remain  <= req.vertex_count;
            prev    <= NONE;
            steps   <= '0;
            // A nonzero allocate with a zero bucket size can never be placed.
            out_reg <= '{status: (req.req_type == REQ_ALLOC &&
                                  req.vertex_count != 26'd0 &&
                                  bucket_size == 16'd0) ? ST_NO_SPACE : ST_OK,
                         result_bucket: 11'(NONE),
                         bucket_fill: 16'd0, free_count: 11'(total)};
            priority if (req.req_type == REQ_ALLOC) begin
              if (req.vertex_count == 26'd0) begin
                state <= S_RESP;
              end else if (bucket_size == 16'd0) begin
                state <= S_RESP;
              end else begin
                state <= S_DIV;
              end
            end else if (req.req_type == REQ_FREE) begin
              state <= S_WLKRD;
            end else if (req.req_type == REQ_QUERY) begin
              state <= (req.bucket_id < 11'(NONE)) ? S_QRD : S_RESP;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_DIV: begin
          steps <= div_done ? '0 : CW'(1);
          if (div_done) begin
            if (div_q > 26'(total)) begin
              out_reg.status <= ST_NO_SPACE;
              state <= S_RESP;
            end else begin
              state <= S_POPRD;
            end
          end
        end
        S_POPRD: begin
          // Queue read for head issues now; data arrives next cycle.
          state <= S_POPWR;
        end
        S_POPWR: begin
          head   <= (head == LAST) ? '0 : head + 1'b1;
          total  <= total - 1'b1;
          prev   <= {1'b0, q_rdata};
          remain <= remain - {10'd0, amount};
          if (remain == {10'd0, amount}) begin
            out_reg <= '{status: out_reg.status,
                         result_bucket: 11'({1'b0, q_rdata}),
                         bucket_fill: out_reg.bucket_fill,
                         free_count: 11'(total - 1'b1)};
            state <= S_RESP;
          end else begin
            state <= S_POPRD;
          end
        end
        S_WLKRD: begin
          if (cur >= NONE || steps == NONE) begin
            out_reg.free_count <= 11'(total);
            state <= S_RESP;
          end else begin
            if (total < NONE) begin
              tail  <= (tail == LAST) ? '0 : tail + 1'b1;
              total <= total + 1'b1;
            end else begin
              out_reg.status <= ST_OVERFLOW;
            end
            steps <= steps + 1'b1;
            state <= S_WLKWR;
          end
        end
        S_WLKWR: begin
          cur   <= n_rdata;
          state <= S_WLKRD;
        end
        S_QRD: state <= S_QWAIT;
        S_QWAIT: begin
          out_reg <= '{status: out_reg.status, result_bucket: 11'(n_rdata),
                       bucket_fill: f_rdata, free_count: out_reg.free_count};
          state <= S_RESP;
        end
        S_RESP: if (rsp_ready) state <= S_IDLE;
        default: state <= S_INIT;
      endcase
    end
  end

  // The free count never exceeds the pool size.
  assert property (@(posedge clk) disable iff (rst) total <= NONE)
    else $error("free count above pool size");
  // A request is only taken when no response is pending.
  assert property (@(posedge clk) disable iff (rst) !(req_ready && rsp_valid))
    else $error("request accepted while response pending");
  // A no-space answer leaves the free count unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NO_SPACE) |-> rsp.free_count == 11'(total))
    else $error("failed allocate changed the pool");

endmodule

@@ rtl/core/bca_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bca_divider.sv @@
// ----------------------------------------------------------------------------
// Bucket count divider
// Radix-2 restoring division giving ceil(count / size), one bit per cycle.
// ----------------------------------------------------------------------------
module bca_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [25:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [25:0] quotient
);

  logic [4:0]  bit_cnt;
  logic        busy;
  logic [25:0] quo;
  logic [16:0] rem;
  logic [15:0] dsr;
  logic [16:0] rem_shift;
  logic [16:0] rem_diff;

  assign rem_shift = {rem[15:0], quo[25]};
  assign rem_diff  = rem_shift - {1'b0, dsr};
  // Round up when any remainder is left.
  assign quotient  = quo + {25'd0, (rem != 17'd0)};

  // Shift-subtract iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= 5'd0;
        quo     <= dividend;
        rem     <= 17'd0;
        dsr     <= divisor;
      end else if (busy) begin
        if (!rem_diff[16]) begin
          rem <= rem_diff;
          quo <= {quo[24:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[24:0], 1'b0};
        end
        bit_cnt <= bit_cnt + 5'd1;
        if (bit_cnt == 5'd25) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
